### src/lci_pkg.sv
package lci_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int SAT_W = (COORD_WIDTH > 16) ? 16 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
	localparam int SAT_MAX = (1 << (SAT_W - 1)) - 1;
	localparam int SAT_MIN = -SAT_MAX - 1;

	localparam int IN_W = 16;
	localparam int R_W = 15;
	localparam int OUT_W = 16;
	localparam int REL_W = IN_W + 1;
	localparam int PROD_W = 2 * REL_W;
	localparam int DET_W = PROD_W + 1;
	localparam int DETN_W = 33;
	localparam int DR2_W = 33;
	localparam int RSQ_W = 2 * R_W;
	localparam int DR2_SPLIT = 17;
	localparam int RRL_W = RSQ_W + DR2_SPLIT;
	localparam int RRH_W = RSQ_W + DR2_W - DR2_SPLIT;
	localparam int DISC_W = 64;
	localparam int ROOT_W = 32;
	localparam int MUL_W = 50;
	localparam int ADY_W = 16;
	localparam int AYS_W = ADY_W + ROOT_W;
	localparam int SUM_W = 51;
	localparam int MAG_W = 50;
	localparam int DIV_W = 51;
	localparam int Q_W = 16;
	localparam int LANES = 4;

	typedef enum logic [1:0] {
		ST_HIT = 2'd0,
		ST_MISS = 2'd1,
		ST_DEGEN = 2'd2
	} status_t;

	typedef struct packed {
		status_t status;
		logic signed [DETN_W-1:0] det;
		logic signed [REL_W-1:0] dx;
		logic signed [REL_W-1:0] dy;
		logic [DR2_W-1:0] dr2;
		logic signed [IN_W-1:0] cx;
		logic signed [IN_W-1:0] cy;
	} geo_t;

	typedef struct packed {
		status_t status;
		logic [LANES-1:0] neg;
		logic signed [IN_W-1:0] cx;
		logic signed [IN_W-1:0] cy;
		logic [DR2_W-1:0] dr2;
	} post_t;

endpackage

### src/lci_front.sv
module lci_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [lci_pkg::IN_W-1:0] line_x1,
	input logic signed [lci_pkg::IN_W-1:0] line_y1,
	input logic signed [lci_pkg::IN_W-1:0] line_x2,
	input logic signed [lci_pkg::IN_W-1:0] line_y2,
	input logic signed [lci_pkg::IN_W-1:0] center_x,
	input logic signed [lci_pkg::IN_W-1:0] center_y,
	input logic [lci_pkg::R_W-1:0] radius,
	output logic out_valid,
	input logic out_ready,
	output lci_pkg::geo_t out_geo,
	output logic [lci_pkg::DISC_W-1:0] out_disc
);
	import lci_pkg::*;

	localparam int NST = 5;

	logic [NST:1] v_q;
	logic [NST+1:1] rdy;

	logic signed [IN_W-1:0] cx_s1, cy_s1;
	logic [R_W-1:0] r_s1;
	logic signed [REL_W-1:0] x1_s1, y1_s1, x2_s1, y2_s1, dx_s1, dy_s1;

	logic signed [PROD_W-1:0] pa_s2, pb_s2, dxx_s2, dyy_s2;
	logic [RSQ_W-1:0] rsq_s2;
	logic signed [REL_W-1:0] dx_s2, dy_s2;
	logic signed [IN_W-1:0] cx_s2, cy_s2;
	logic degen_s2;

	logic signed [DET_W-1:0] det_c, adet_c;
	logic signed [DETN_W-1:0] det_s3;
	logic [ROOT_W-1:0] adet_s3;
	logic big_s3;
	logic [DR2_W-1:0] dr2_s3;
	logic [RSQ_W-1:0] rsq_s3;
	logic signed [REL_W-1:0] dx_s3, dy_s3;
	logic signed [IN_W-1:0] cx_s3, cy_s3;
	logic degen_s3;

	logic [RRL_W-1:0] rrl_s4;
	logic [RRH_W-1:0] rrh_s4;
	logic [DISC_W-1:0] aa_s4;
	logic signed [DETN_W-1:0] det_s4;
	logic big_s4;
	logic [DR2_W-1:0] dr2_s4;
	logic signed [REL_W-1:0] dx_s4, dy_s4;
	logic signed [IN_W-1:0] cx_s4, cy_s4;
	logic degen_s4;

	logic [DISC_W-1:0] rr_c;
	status_t st_c;
	geo_t geo_s5;
	logic [DISC_W-1:0] disc_s5;

	always_comb begin
		rdy[NST+1] = out_ready;
		for (int k = NST; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[1];
	assign out_valid = v_q[NST];
	assign out_geo = geo_s5;
	assign out_disc = disc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	always_comb begin
		det_c = DET_W'(pa_s2) - DET_W'(pb_s2);
		adet_c = (det_c < 0) ? -det_c : det_c;
		rr_c = DISC_W'(rrl_s4) + (DISC_W'(rrh_s4) << DR2_SPLIT);
		if (degen_s4) begin
			st_c = ST_DEGEN;
		end else if (big_s4 || (aa_s4 > rr_c)) begin
			st_c = ST_MISS;
		end else begin
			st_c = ST_HIT;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			cx_s1 <= center_x;
			cy_s1 <= center_y;
			r_s1 <= radius;
			x1_s1 <= REL_W'(line_x1) - REL_W'(center_x);
			y1_s1 <= REL_W'(line_y1) - REL_W'(center_y);
			x2_s1 <= REL_W'(line_x2) - REL_W'(center_x);
			y2_s1 <= REL_W'(line_y2) - REL_W'(center_y);
			dx_s1 <= REL_W'(line_x2) - REL_W'(line_x1);
			dy_s1 <= REL_W'(line_y2) - REL_W'(line_y1);
		end
		if (rdy[2]) begin
			pa_s2 <= PROD_W'(x1_s1) * PROD_W'(y2_s1);
			pb_s2 <= PROD_W'(x2_s1) * PROD_W'(y1_s1);
			dxx_s2 <= PROD_W'(dx_s1) * PROD_W'(dx_s1);
			dyy_s2 <= PROD_W'(dy_s1) * PROD_W'(dy_s1);
			rsq_s2 <= RSQ_W'(r_s1) * RSQ_W'(r_s1);
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			degen_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
		end
		if (rdy[3]) begin
			det_s3 <= det_c[DETN_W-1:0];
			adet_s3 <= adet_c[ROOT_W-1:0];
			big_s3 <= |adet_c[DET_W-1:ROOT_W];
			dr2_s3 <= DR2_W'(dxx_s2 + dyy_s2);
			rsq_s3 <= rsq_s2;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			degen_s3 <= degen_s2;
		end
		if (rdy[4]) begin
			rrl_s4 <= RRL_W'(rsq_s3) * RRL_W'(dr2_s3[DR2_SPLIT-1:0]);
			rrh_s4 <= RRH_W'(rsq_s3) * RRH_W'(dr2_s3[DR2_W-1:DR2_SPLIT]);
			aa_s4 <= DISC_W'(adet_s3) * DISC_W'(adet_s3);
			det_s4 <= det_s3;
			big_s4 <= big_s3;
			dr2_s4 <= dr2_s3;
			dx_s4 <= dx_s3;
			dy_s4 <= dy_s3;
			cx_s4 <= cx_s3;
			cy_s4 <= cy_s3;
			degen_s4 <= degen_s3;
		end
		if (rdy[5]) begin
			geo_s5.status <= st_c;
			geo_s5.det <= det_s4;
			geo_s5.dx <= dx_s4;
			geo_s5.dy <= dy_s4;
			geo_s5.dr2 <= dr2_s4;
			geo_s5.cx <= cx_s4;
			geo_s5.cy <= cy_s4;
			disc_s5 <= rr_c - aa_s4;
		end
	end

endmodule

### src/lci_sqrt.sv
module lci_sqrt (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lci_pkg::geo_t in_geo,
	input logic [lci_pkg::DISC_W-1:0] in_disc,
	output logic out_valid,
	input logic out_ready,
	output lci_pkg::geo_t out_geo,
	output logic [lci_pkg::ROOT_W-1:0] out_root
);
	import lci_pkg::*;

	// One result bit per stage, most significant first.
	logic [ROOT_W-1:0] v_q;
	logic [ROOT_W:0] rdy;
	geo_t geo_s [ROOT_W];
	logic [DISC_W-1:0] rem_s [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];

	always_comb begin
		rdy[ROOT_W] = out_ready;
		for (int k = ROOT_W - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[0];
	assign out_valid = v_q[ROOT_W-1];
	assign out_geo = geo_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < ROOT_W; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_st
		localparam int I = ROOT_W - 1 - k;
		logic [DISC_W-1:0] rem_in, trial;
		logic [ROOT_W-1:0] root_in;
		geo_t geo_in;

		if (k == 0) begin : g_first
			assign rem_in = in_disc;
			assign root_in = '0;
			assign geo_in = in_geo;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign geo_in = geo_s[k-1];
		end

		// Bits of the partial root below this position are still zero, so OR adds.
		assign trial = (DISC_W'(root_in) << (I + 1)) | (DISC_W'(1) << (2 * I));

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				geo_s[k] <= geo_in;
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					root_s[k] <= root_in | (ROOT_W'(1) << I);
				end else begin
					rem_s[k] <= rem_in;
					root_s[k] <= root_in;
				end
			end
		end
	end

	a_floor_root: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ROOT_W-1] && (geo_s[ROOT_W-1].status == ST_HIT)
		|-> (rem_s[ROOT_W-1] <= {root_s[ROOT_W-1], 1'b0}))
		else $error("square root remainder exceeds twice the root");

endmodule

### src/lci_prep.sv
module lci_prep (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lci_pkg::geo_t in_geo,
	input logic [lci_pkg::ROOT_W-1:0] in_root,
	output logic out_valid,
	input logic out_ready,
	output lci_pkg::post_t out_post,
	output logic [lci_pkg::LANES-1:0][lci_pkg::DIV_W-1:0] out_num
);
	import lci_pkg::*;

	localparam int NST = 3;

	logic [NST:1] v_q;
	logic [NST+1:1] rdy;

	logic signed [REL_W-1:0] ady_c;
	logic signed [MUL_W-1:0] xa_s1, dxs_s1, dtx_s1;
	logic [AYS_W-1:0] ays_s1;
	logic negdy_s1;
	post_t post_s1, post_s2, post_s3;

	logic signed [SUM_W-1:0] xb_c;
	logic signed [LANES-1:0][SUM_W-1:0] n_s2;

	logic [LANES-1:0] neg_c;
	logic [LANES-1:0][DIV_W-1:0] num_c;
	logic [LANES-1:0][DIV_W-1:0] num_s3;

	always_comb begin
		rdy[NST+1] = out_ready;
		for (int k = NST; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[1];
	assign out_valid = v_q[NST];
	assign out_post = post_s3;
	assign out_num = num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0] mag;
		ady_c = (in_geo.dy < 0) ? -in_geo.dy : in_geo.dy;
		xb_c = negdy_s1 ? -SUM_W'(dxs_s1) : SUM_W'(dxs_s1);
		for (int l = 0; l < LANES; l++) begin
			neg_c[l] = n_s2[l][SUM_W-1];
			mag = neg_c[l] ? -n_s2[l] : n_s2[l];
			num_c[l] = DIV_W'({mag[MAG_W-1:0], 1'b0}) + DIV_W'(post_s2.dr2);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			xa_s1 <= MUL_W'(in_geo.det) * MUL_W'(in_geo.dy);
			dxs_s1 <= MUL_W'(in_geo.dx) * MUL_W'({1'b0, in_root});
			dtx_s1 <= MUL_W'(in_geo.det) * MUL_W'(in_geo.dx);
			ays_s1 <= AYS_W'(ady_c[ADY_W-1:0]) * AYS_W'(in_root);
			negdy_s1 <= in_geo.dy < 0;
			post_s1.status <= in_geo.status;
			post_s1.neg <= '0;
			post_s1.cx <= in_geo.cx;
			post_s1.cy <= in_geo.cy;
			post_s1.dr2 <= in_geo.dr2;
		end
		if (rdy[2]) begin
			// Lanes: first x, first y, second x, second y.
			n_s2[0] <= SUM_W'(xa_s1) + xb_c;
			n_s2[1] <= SUM_W'(ays_s1) - SUM_W'(dtx_s1);
			n_s2[2] <= SUM_W'(xa_s1) - xb_c;
			n_s2[3] <= -SUM_W'(dtx_s1) - SUM_W'(ays_s1);
			post_s2 <= post_s1;
		end
		if (rdy[3]) begin
			num_s3 <= num_c;
			post_s3.status <= post_s2.status;
			post_s3.neg <= neg_c;
			post_s3.cx <= post_s2.cx;
			post_s3.cy <= post_s2.cy;
			post_s3.dr2 <= post_s2.dr2;
		end
	end

endmodule

### src/lci_div.sv
module lci_div (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lci_pkg::post_t in_post,
	input logic [lci_pkg::LANES-1:0][lci_pkg::DIV_W-1:0] in_num,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic signed [lci_pkg::OUT_W-1:0] first_x,
	output logic signed [lci_pkg::OUT_W-1:0] first_y,
	output logic signed [lci_pkg::OUT_W-1:0] second_x,
	output logic signed [lci_pkg::OUT_W-1:0] second_y,
	output logic clipped
);
	import lci_pkg::*;

	// Q_W restoring steps, one quotient bit each, then an offset and saturation stage.
	localparam int NST = Q_W + 1;

	logic [NST-1:0] v_q;
	logic [NST:0] rdy;
	post_t post_s [Q_W];
	logic [LANES-1:0][DIV_W-1:0] rem_s [Q_W];
	logic [LANES-1:0][Q_W-1:0] q_s [Q_W];

	status_t fin_status_s;
	logic [LANES-1:0][OUT_W-1:0] fin_coord_s;
	logic fin_clip_s;

	logic [LANES-1:0][OUT_W-1:0] crd_c;
	logic [LANES-1:0] clip_c;

	always_comb begin
		rdy[NST] = out_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[0];
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_st
		localparam int I = Q_W - 1 - k;
		post_t post_in;
		logic [LANES-1:0][DIV_W-1:0] rem_in;
		logic [LANES-1:0][Q_W-1:0] q_in;
		logic [DIV_W-1:0] dsh;

		if (k == 0) begin : g_first
			assign post_in = in_post;
			assign rem_in = in_num;
			assign q_in = '0;
		end else begin : g_next
			assign post_in = post_s[k-1];
			assign rem_in = rem_s[k-1];
			assign q_in = q_s[k-1];
		end

		// Divisor is twice the squared length, which makes the quotient round to nearest.
		assign dsh = DIV_W'({post_in.dr2, 1'b0}) << I;

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				post_s[k] <= post_in;
				for (int l = 0; l < LANES; l++) begin
					if (rem_in[l] >= dsh) begin
						rem_s[k][l] <= rem_in[l] - dsh;
						q_s[k][l] <= q_in[l] | (Q_W'(1) << I);
					end else begin
						rem_s[k][l] <= rem_in[l];
						q_s[k][l] <= q_in[l];
					end
				end
			end
		end
	end

	always_comb begin
		logic signed [Q_W:0] qs;
		logic signed [Q_W+1:0] val;
		logic signed [IN_W-1:0] c;
		for (int l = 0; l < LANES; l++) begin
			c = l[0] ? post_s[Q_W-1].cy : post_s[Q_W-1].cx;
			qs = post_s[Q_W-1].neg[l] ? -$signed({1'b0, q_s[Q_W-1][l]})
				: $signed({1'b0, q_s[Q_W-1][l]});
			val = (Q_W + 2)'(qs) + (Q_W + 2)'(c);
			clip_c[l] = 1'b0;
			if (val > SAT_MAX) begin
				crd_c[l] = OUT_W'(SAT_MAX);
				clip_c[l] = 1'b1;
			end else if (val < SAT_MIN) begin
				crd_c[l] = OUT_W'(SAT_MIN);
				clip_c[l] = 1'b1;
			end else begin
				crd_c[l] = OUT_W'(val);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[Q_W]) begin
			fin_status_s <= post_s[Q_W-1].status;
			if (post_s[Q_W-1].status == ST_HIT) begin
				fin_coord_s <= crd_c;
				fin_clip_s <= |clip_c;
			end else begin
				fin_coord_s <= '0;
				fin_clip_s <= 1'b0;
			end
		end
	end

	assign status = fin_status_s;
	assign first_x = fin_coord_s[0];
	assign first_y = fin_coord_s[1];
	assign second_x = fin_coord_s[2];
	assign second_y = fin_coord_s[3];
	assign clipped = fin_clip_s;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[Q_W-1] && (post_s[Q_W-1].status == ST_HIT)
		|-> (rem_s[Q_W-1][0] < DIV_W'({post_s[Q_W-1].dr2, 1'b0}))
			&& (rem_s[Q_W-1][1] < DIV_W'({post_s[Q_W-1].dr2, 1'b0}))
			&& (rem_s[Q_W-1][2] < DIV_W'({post_s[Q_W-1].dr2, 1'b0}))
			&& (rem_s[Q_W-1][3] < DIV_W'({post_s[Q_W-1].dr2, 1'b0})))
		else $error("quotient too narrow for a crossing");

endmodule

### src/line_circle_intersection_top.sv
// Line and circle crossing engine. Each transfer on the input carries two points of an
// infinite line and a circle; each output transfer returns a status (0 crossing, 1 miss,
// 2 coincident points), both crossing points rounded to nearest and saturated, and a clip
// flag; coordinates are zero unless status is 0. One item is taken per clock cycle
// while the output is not held back, and results leave in order through 57 register
// stages: 5 stages of products and discriminant, 32 stages of the bit-per-stage square
// root, 3 stages of numerator forming, and 16 stages of the bit-per-stage divider plus
// one offset and saturation stage.
module line_circle_intersection_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [lci_pkg::IN_W-1:0] line_x1,
	input logic signed [lci_pkg::IN_W-1:0] line_y1,
	input logic signed [lci_pkg::IN_W-1:0] line_x2,
	input logic signed [lci_pkg::IN_W-1:0] line_y2,
	input logic signed [lci_pkg::IN_W-1:0] center_x,
	input logic signed [lci_pkg::IN_W-1:0] center_y,
	input logic [lci_pkg::R_W-1:0] radius,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic signed [lci_pkg::OUT_W-1:0] first_x,
	output logic signed [lci_pkg::OUT_W-1:0] first_y,
	output logic signed [lci_pkg::OUT_W-1:0] second_x,
	output logic signed [lci_pkg::OUT_W-1:0] second_y,
	output logic clipped
);
	import lci_pkg::*;

	logic fr_valid, fr_ready;
	geo_t fr_geo;
	logic [DISC_W-1:0] fr_disc;

	logic sq_valid, sq_ready;
	geo_t sq_geo;
	logic [ROOT_W-1:0] sq_root;

	logic pp_valid, pp_ready;
	post_t pp_post;
	logic [LANES-1:0][DIV_W-1:0] pp_num;

	lci_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.line_x1(line_x1), .line_y1(line_y1), .line_x2(line_x2), .line_y2(line_y2),
		.center_x(center_x), .center_y(center_y), .radius(radius),
		.out_valid(fr_valid), .out_ready(fr_ready), .out_geo(fr_geo), .out_disc(fr_disc)
	);

	lci_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fr_valid), .in_ready(fr_ready), .in_geo(fr_geo), .in_disc(fr_disc),
		.out_valid(sq_valid), .out_ready(sq_ready), .out_geo(sq_geo), .out_root(sq_root)
	);

	lci_prep u_prep (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq_valid), .in_ready(sq_ready), .in_geo(sq_geo), .in_root(sq_root),
		.out_valid(pp_valid), .out_ready(pp_ready), .out_post(pp_post), .out_num(pp_num)
	);

	lci_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pp_valid), .in_ready(pp_ready), .in_post(pp_post), .in_num(pp_num),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .first_x(first_x), .first_y(first_y),
		.second_x(second_x), .second_y(second_y), .clipped(clipped)
	);

	a_empty_out_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output is empty");

	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_HIT)
		|-> (first_x == '0) && (first_y == '0) && (second_x == '0) && (second_y == '0)
			&& !clipped)
		else $error("non-zero coordinates without a crossing");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_HIT) || (status == ST_MISS) || (status == ST_DEGEN))
		else $error("bad status");

endmodule

### tb/tb_line_circle_intersection_top.sv
module tb_line_circle_intersection_top;
	import lci_pkg::*;

	typedef struct {
		logic signed [15:0] x1, y1, x2, y2, cx, cy;
		logic [14:0] r;
	} query_t;

	typedef struct {
		status_t st;
		logic signed [15:0] fx, fy, sx, sy;
		logic clip;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] line_x1 = '0, line_y1 = '0, line_x2 = '0, line_y2 = '0;
	logic signed [15:0] center_x = '0, center_y = '0;
	logic [14:0] radius = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic signed [15:0] first_x, first_y, second_x, second_y;
	logic clipped;

	query_t pending_q[$];
	answer_t answer_q[$];
	query_t cur_query;
	int unsigned sender_idle = 0;
	int unsigned receiver_stall = 0;
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned quiet_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int unsigned hold_cnt = 0;

	line_circle_intersection_top dut (.*);

	always #10 clk = ~clk;

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint round_div(longint num, logic [63:0] den);
		logic [63:0] mag, q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [15:0] saturate(longint v, inout logic clip);
		if (v > SAT_MAX) begin
			v = SAT_MAX;
			clip = 1'b1;
		end
		if (v < SAT_MIN) begin
			v = SAT_MIN;
			clip = 1'b1;
		end
		return v[15:0];
	endfunction

	function automatic answer_t crossing_of(query_t q);
		answer_t a;
		longint cx, cy, x1, y1, x2, y2, dx, dy, det, sg, xa, xb, ya, yb;
		logic [63:0] dr2, adet, rr, s, rv;
		a = '{ST_HIT, '0, '0, '0, '0, 1'b0};
		cx = q.cx;
		cy = q.cy;
		x1 = q.x1 - cx;
		y1 = q.y1 - cy;
		x2 = q.x2 - cx;
		y2 = q.y2 - cy;
		dx = x2 - x1;
		dy = y2 - y1;
		if (dx == 0 && dy == 0) begin
			a.st = ST_DEGEN;
			return a;
		end
		dr2 = dx * dx + dy * dy;
		det = x1 * y2 - x2 * y1;
		adet = (det < 0) ? -det : det;
		rv = {49'd0, q.r};
		rr = rv * rv * dr2;
		if (adet >= (64'd1 << 32) || adet * adet > rr) begin
			a.st = ST_MISS;
			return a;
		end
		s = floor_sqrt(rr - adet * adet);
		sg = (dy < 0) ? -1 : 1;
		xa = det * dy;
		xb = sg * dx * longint'(s);
		ya = -det * dx;
		yb = ((dy < 0) ? -dy : dy) * longint'(s);
		a.fx = saturate(round_div(xa + xb, dr2) + cx, a.clip);
		a.fy = saturate(round_div(ya + yb, dr2) + cy, a.clip);
		a.sx = saturate(round_div(xa - xb, dr2) + cx, a.clip);
		a.sy = saturate(round_div(ya - yb, dr2) + cy, a.clip);
		return a;
	endfunction

	function automatic logic signed [15:0] near(logic signed [15:0] c, int span);
		longint v;
		v = longint'(c) + $signed($urandom_range(2 * span)) - span;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] pick_extreme();
		case ($urandom_range(3))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		int unsigned mode, span;
		q.cx = 16'($urandom);
		q.cy = 16'($urandom);
		q.r = 15'($urandom);
		mode = $urandom_range(99);
		if (mode < 20) begin
			q.x1 = 16'($urandom);
			q.y1 = 16'($urandom);
			q.x2 = 16'($urandom);
			q.y2 = 16'($urandom);
		end else if (mode < 30) begin
			q.x1 = 16'($urandom);
			q.y1 = 16'($urandom);
			q.x2 = q.x1;
			q.y2 = q.y1;
		end else if (mode < 38) begin
			q.x1 = pick_extreme();
			q.y1 = pick_extreme();
			q.x2 = pick_extreme();
			q.y2 = pick_extreme();
			q.cx = pick_extreme();
			q.cy = pick_extreme();
			q.r = $urandom_range(1) ? 15'h7fff : 15'h0000;
		end else if (mode < 48) begin
			// Horizontal or vertical tangent lines.
			q.r = 15'($urandom_range(2000));
			q.x1 = near(q.cx, 3000);
			q.y1 = near(q.cy + q.r, 0);
			q.x2 = near(q.cx, 3000);
			q.y2 = q.y1;
			if ($urandom_range(1)) begin
				q.y1 = near(q.cy, 3000);
				q.x1 = near(q.cx - q.r, 0);
				q.y2 = near(q.cy, 3000);
				q.x2 = q.x1;
			end
		end else if (mode < 53) begin
			// Zero radius with a line through the center.
			q.r = '0;
			q.x1 = near(q.cx, 100);
			q.y1 = near(q.cy, 100);
			q.x2 = q.cx + (q.cx - q.x1);
			q.y2 = q.cy + (q.cy - q.y1);
		end else begin
			// Mostly crossings: points placed around the circle.
			span = $urandom_range(1) ? 300 : 30000;
			q.r = 15'($urandom_range(span));
			q.x1 = near(q.cx, span);
			q.y1 = near(q.cy, span);
			q.x2 = near(q.cx, span);
			q.y2 = near(q.cy, span);
		end
		return q;
	endfunction

	task automatic add_query(query_t q);
		pending_q.push_back(q);
		queued_cnt++;
	endtask

	task automatic add_directed(int x1, int y1, int x2, int y2, int cx, int cy, int r);
		query_t q;
		q = '{x1[15:0], y1[15:0], x2[15:0], y2[15:0], cx[15:0], cy[15:0], r[14:0]};
		add_query(q);
	endtask

	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || answer_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n);
		sender_idle = idle;
		receiver_stall = stall;
		repeat (n)
			add_query(random_query());
		wait_drained();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				answer_q.push_back(crossing_of(cur_query));
				accepted_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
					cur_query = pending_q.pop_front();
					line_x1 <= cur_query.x1;
					line_y1 <= cur_query.y1;
					line_x2 <= cur_query.x2;
					line_y2 <= cur_query.y2;
					center_x <= cur_query.cx;
					center_y <= cur_query.cy;
					radius <= cur_query.r;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result transfer, status %0d", status);
				end else begin
					e = answer_q.pop_front();
					if (status !== e.st || first_x !== e.fx || first_y !== e.fy ||
						second_x !== e.sx || second_y !== e.sy || clipped !== e.clip) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"mismatch: exp %0d (%0d,%0d) (%0d,%0d) c%0d",
								" got %0d (%0d,%0d) (%0d,%0d) c%0d"},
								e.st, e.fx, e.fy, e.sx, e.sy, e.clip,
								status, first_x, first_y, second_x, second_y, clipped);
					end
				end
			end
			if (hold_req && !hold_done) begin
				// Long receiver hold-off so the pipeline backs up into the input.
				out_ready <= 1'b0;
				hold_cnt++;
				if (hold_cnt >= 300)
					hold_done = 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_stall);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 20000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_directed(-32768, -32768, 32767, 32767, 0, 0, 32767);
		add_directed(32767, -32768, -32768, 32767, 32767, 32767, 32767);
		add_directed(-32768, 32767, -32768, 32767, 0, 0, 100);
		add_directed(5, 5, 5, 5, -32768, 32767, 0);
		add_directed(-100, 50, 100, 50, 0, 0, 10);
		add_directed(-100, 10, 100, 10, 0, 0, 10);
		add_directed(-10, -100, -10, 100, 0, 0, 10);
		add_directed(-3, -4, 3, 4, 0, 0, 0);
		add_directed(-3, -4, 3, 5, 0, 0, 0);
		add_directed(-32768, 32767, 32767, 32767, -32768, -32768, 0);
		add_directed(-32768, -32768, 32767, -32767, 32767, 32767, 1);
		add_directed(-1000, 32767, 1000, 32767, 0, 32767, 32767);
		add_directed(32767, -1000, 32767, 1000, 32767, 0, 32767);
		add_directed(-32768, -1000, -32768, 1000, -32768, 0, 32767);
		add_directed(0, 0, 1, 0, 0, 0, 32767);
		add_directed(0, 0, 0, -1, 0, 0, 32767);
		add_directed(1, 2, 7, -3, 2, 1, 5);
		add_directed(-5, 3, 4, -6, -1, -1, 3);
		add_directed(0, 0, 3, 4, 0, 0, 5);
		add_directed(-32768, 0, 32767, 1, 0, 0, 32767);
		wait_drained();

		run_phase(0, 0, 250);
		run_phase(88, 0, 200);
		run_phase(0, 88, 200);
		run_phase(19, 19, 250);

		sender_idle = 0;
		receiver_stall = 0;
		hold_req = 1'b1;
		repeat (150)
			add_query(random_query());
		wait_drained();
		hold_req = 1'b0;

		run_phase(0, 0, 150);

		repeat (100) @(posedge clk);
		if (mismatch_cnt == 0 && answer_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

### files.f
src/lci_pkg.sv
src/lci_front.sv
src/lci_sqrt.sv
src/lci_prep.sv
src/lci_div.sv
src/line_circle_intersection_top.sv
tb/tb_line_circle_intersection_top.sv
